@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, ignored while reset is applied.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on every rising edge of clk, ignored while reset is applied.
`define ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hdl/bpa_pkg.sv @@
package bpa_pkg;

	localparam int FRAME_W  = 36;
	localparam int ORD_W    = 4;
	localparam int REGION_W = 17;
	localparam int STAT_W   = 2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_MEMORY = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_ORDER = 2'd2;
	localparam logic [STAT_W-1:0] ST_OUTSIDE   = 2'd3;

	localparam logic CFG_BASE_PFN     = 1'b0;
	localparam logic CFG_REGION_PAGES = 1'b1;

	typedef struct packed {
		logic               command;
		logic [ORD_W-1:0]   order;
		logic [FRAME_W-1:0] page_frame;
	} req_word_t;

	typedef struct packed {
		logic [FRAME_W-1:0] result_frame;
		logic [STAT_W-1:0]  status;
	} rsp_word_t;

	typedef enum logic [4:0] {
		DC_NOP, DC_CFG, DC_CLEAR, DC_CARVE, DC_ACCEPT, DC_CHECK, DC_SCAN,
		DC_URD, DC_UW1, DC_UW2, DC_SPLIT, DC_PUSHA, DC_PUSHB, DC_AFIN,
		DC_FCLR, DC_MCHK, DC_MEVAL, DC_MPOST, DC_FPUSH, DC_DONE
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic carve_done;
		logic bad_order;
		logic out_range;
		logic cmd_free;
		logic head_valid;
		logic cur_last;
		logic split_done;
		logic merge_stop;
		logic merge_ok;
		logic rsp_free;
	} dp_stat_t;

endpackage

@@ hdl/bpa_ram.sv @@
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/bpa_ctrl.sv @@
module bpa_ctrl import bpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     req_valid,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     idle
);

	typedef enum logic [18:0] {
		S_CFG    = 19'h00001,
		S_CLEAR  = 19'h00002,
		S_CARVE  = 19'h00004,
		S_IDLE   = 19'h00008,
		S_CHECK  = 19'h00010,
		S_SCAN   = 19'h00020,
		S_U_RD   = 19'h00040,
		S_U_W1   = 19'h00080,
		S_U_W2   = 19'h00100,
		S_SPLIT  = 19'h00200,
		S_PUSH_A = 19'h00400,
		S_PUSH_B = 19'h00800,
		S_A_FIN  = 19'h01000,
		S_F_CLR  = 19'h02000,
		S_M_CHK  = 19'h04000,
		S_M_EVAL = 19'h08000,
		S_M_POST = 19'h10000,
		S_F_PUSH = 19'h20000,
		S_DONE   = 19'h40000
	} state_t;

	state_t state_q, state_nxt;
	logic   carving_q;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = DC_NOP;
		unique case (state_q)
			S_CFG: begin
				cmd       = DC_CFG;
				state_nxt = S_CLEAR;
			end
			S_CLEAR: begin
				cmd = DC_CLEAR;
				if (stat.clr_last) begin
					state_nxt = S_CARVE;
				end
			end
			S_CARVE: begin
				if (stat.carve_done) begin
					state_nxt = S_IDLE;
				end else begin
					cmd       = DC_CARVE;
					state_nxt = S_PUSH_A;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd       = DC_ACCEPT;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd = DC_CHECK;
				if (stat.bad_order) begin
					state_nxt = S_DONE;
				end else if (!stat.cmd_free) begin
					state_nxt = S_SCAN;
				end else if (stat.out_range) begin
					state_nxt = S_DONE;
				end else begin
					state_nxt = S_F_CLR;
				end
			end
			S_SCAN: begin
				cmd = DC_SCAN;
				if (stat.head_valid) begin
					state_nxt = S_U_RD;
				end else if (stat.cur_last) begin
					state_nxt = S_DONE;
				end
			end
			S_U_RD: begin
				cmd       = DC_URD;
				state_nxt = S_U_W1;
			end
			S_U_W1: begin
				cmd       = DC_UW1;
				state_nxt = S_U_W2;
			end
			S_U_W2: begin
				cmd       = DC_UW2;
				state_nxt = stat.cmd_free ? S_M_POST : S_SPLIT;
			end
			S_SPLIT: begin
				cmd       = DC_SPLIT;
				state_nxt = stat.split_done ? S_A_FIN : S_PUSH_A;
			end
			S_PUSH_A: begin
				cmd       = DC_PUSHA;
				state_nxt = S_PUSH_B;
			end
			S_PUSH_B: begin
				cmd = DC_PUSHB;
				if (carving_q) begin
					state_nxt = S_CARVE;
				end else if (stat.cmd_free) begin
					state_nxt = S_DONE;
				end else begin
					state_nxt = S_SPLIT;
				end
			end
			S_A_FIN: begin
				cmd       = DC_AFIN;
				state_nxt = S_DONE;
			end
			S_F_CLR: begin
				cmd       = DC_FCLR;
				state_nxt = S_M_CHK;
			end
			S_M_CHK: begin
				cmd       = DC_MCHK;
				state_nxt = stat.merge_stop ? S_F_PUSH : S_M_EVAL;
			end
			S_M_EVAL: begin
				cmd       = DC_MEVAL;
				state_nxt = stat.merge_ok ? S_U_RD : S_F_PUSH;
			end
			S_M_POST: begin
				cmd       = DC_MPOST;
				state_nxt = S_M_CHK;
			end
			S_F_PUSH: begin
				cmd       = DC_FPUSH;
				state_nxt = S_PUSH_A;
			end
			S_DONE: begin
				cmd = DC_DONE;
				if (stat.rsp_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CFG;
			end
		endcase
		if (cfg_we) begin
			cmd       = DC_NOP;
			state_nxt = S_CFG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CFG;
			carving_q <= 1'b1;
		end else begin
			state_q <= state_nxt;
			if (state_nxt == S_CFG) begin
				carving_q <= 1'b1;
			end else if (state_nxt == S_IDLE) begin
				carving_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/bpa_dp.sv @@
module bpa_dp import bpa_pkg::*; #(
	parameter int MAX_PAGES  = 65536,
	parameter int NUM_ORDERS = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [FRAME_W-1:0] cfg_data,
	input  req_word_t         req,
	input  logic              rsp_stall,
	output logic              rsp_valid,
	output rsp_word_t         rsp,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat
);

	localparam int IW = $clog2(MAX_PAGES);
	localparam int LW = IW + 1;
	localparam int OW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
	localparam int EW = FRAME_W + 1;
	localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};
	localparam logic [ORD_W-1:0] ORD_LAST = ORD_W'(NUM_ORDERS - 1);
	localparam logic [ORD_W:0] ORD_LIM = (ORD_W+1)'(NUM_ORDERS);

	logic [FRAME_W-1:0]  base_q;
	logic [REGION_W-1:0] region_q;
	logic [EW-1:0]       end_q;
	logic [EW-1:0]       pfn_q;
	logic [LW-1:0]       clr_q;
	logic                cmd_q;
	logic [ORD_W-1:0]    ord_q;
	logic [ORD_W-1:0]    cur_q;
	logic [IW-1:0]       uidx_q;
	logic [IW-1:0]       pidx_q;
	logic [LW-1:0]       h_q;
	logic [STAT_W-1:0]   st_q;
	logic [FRAME_W-1:0]  res_q;
	logic [LW-1:0]       head_q [NUM_ORDERS];
	logic                rsp_valid_q;
	rsp_word_t           rsp_q;

	logic [LW-1:0]    next_rd, prev_rd;
	logic             mark_rd;
	logic [ORD_W-1:0] ord_rd;

	logic [LW-1:0]    head_cur;
	logic [ORD_W-1:0] fit;
	logic [EW-1:0]    space, pages, region_ext, max_ext;
	logic [EW-1:0]    bud;
	logic [IW-1:0]    bi, pfn_idx;
	logic [EW-1:0]    blk_end;

	logic             next_we, prev_we, mark_we, ord_we;
	logic [IW-1:0]    next_wa, prev_wa, mark_wa, ord_wa;
	logic [LW-1:0]    next_wd, prev_wd;
	logic             mark_wd;
	logic [ORD_W-1:0] ord_wd;

	assign head_cur = ({1'b0, cur_q} < ORD_LIM) ? head_q[cur_q[OW-1:0]] : NIL;

	// Bounded region size, so that the region never runs past the frame space.
	assign space      = (EW'(1) << FRAME_W) - EW'(base_q);
	assign region_ext = EW'(region_q);
	assign max_ext    = EW'(MAX_PAGES);
	always_comb begin
		pages = region_ext;
		if (max_ext < pages) begin
			pages = max_ext;
		end
		if (space < pages) begin
			pages = space;
		end
	end

	// Largest aligned block that fits at the carving position.
	always_comb begin
		fit = '0;
		for (int o = 1; o < NUM_ORDERS; o++) begin
			if ((pfn_q & ((EW'(1) << o) - EW'(1))) == '0 &&
				(pfn_q + (EW'(1) << o)) <= end_q) begin
				fit = ORD_W'(o);
			end
		end
	end

	assign bud     = pfn_q ^ (EW'(1) << cur_q);
	assign bi      = IW'(bud - EW'(base_q));
	assign pfn_idx = IW'(pfn_q - EW'(base_q));
	assign blk_end = pfn_q + (EW'(1) << ord_q);

	always_comb begin
		stat            = '0;
		stat.clr_last   = (clr_q[IW-1:0] == {IW{1'b1}});
		stat.carve_done = (pfn_q >= end_q);
		stat.bad_order  = ({1'b0, ord_q} >= ORD_LIM);
		stat.out_range  = (pfn_q < EW'(base_q)) || (blk_end > end_q);
		stat.cmd_free   = (cmd_q == CMD_FREE);
		stat.head_valid = !head_cur[IW];
		stat.cur_last   = (cur_q == ORD_LAST);
		stat.split_done = (cur_q == ord_q);
		stat.merge_stop = (cur_q == ORD_LAST) || (bud < EW'(base_q)) || (bud >= end_q);
		stat.merge_ok   = mark_rd && (ord_rd == cur_q);
		stat.rsp_free   = !rsp_valid_q || !rsp_stall;
	end

	// Write ports of the metadata memories.
	always_comb begin
		next_we = 1'b0; next_wa = pidx_q; next_wd = head_cur;
		prev_we = 1'b0; prev_wa = pidx_q; prev_wd = NIL;
		mark_we = 1'b0; mark_wa = pidx_q; mark_wd = 1'b0;
		ord_we  = 1'b0; ord_wa  = pidx_q; ord_wd  = cur_q;
		case (cmd)
			DC_CLEAR: begin
				mark_we = 1'b1;
				mark_wa = clr_q[IW-1:0];
			end
			DC_PUSHA: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				mark_we = 1'b1;
				mark_wd = 1'b1;
				ord_we  = 1'b1;
			end
			DC_PUSHB: begin
				prev_we = !h_q[IW];
				prev_wa = h_q[IW-1:0];
				prev_wd = {1'b0, pidx_q};
			end
			DC_UW1: begin
				next_we = !prev_rd[IW];
				next_wa = prev_rd[IW-1:0];
				next_wd = next_rd;
				prev_we = !next_rd[IW];
				prev_wa = next_rd[IW-1:0];
				prev_wd = prev_rd;
			end
			DC_UW2: begin
				next_we = 1'b1;
				next_wa = uidx_q;
				next_wd = NIL;
				prev_we = 1'b1;
				prev_wa = uidx_q;
			end
			DC_AFIN: begin
				mark_we = 1'b1;
				mark_wa = uidx_q;
				ord_we  = 1'b1;
				ord_wa  = uidx_q;
				ord_wd  = ord_q;
			end
			DC_FCLR: begin
				mark_we = 1'b1;
				mark_wa = pfn_idx;
			end
			DC_MPOST: begin
				mark_we = 1'b1;
				mark_wa = uidx_q;
			end
			default: begin
			end
		endcase
	end

	bpa_ram #(.WIDTH(LW), .DEPTH(MAX_PAGES)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(uidx_q), .rdata(next_rd)
	);

	bpa_ram #(.WIDTH(LW), .DEPTH(MAX_PAGES)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(uidx_q), .rdata(prev_rd)
	);

	bpa_ram #(.WIDTH(1), .DEPTH(MAX_PAGES)) u_mark_ram (
		.clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
		.raddr(bi), .rdata(mark_rd)
	);

	bpa_ram #(.WIDTH(ORD_W), .DEPTH(MAX_PAGES)) u_ord_ram (
		.clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
		.raddr(bi), .rdata(ord_rd)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			region_q <= REGION_W'(65536);
		end else if (cfg_we) begin
			if (cfg_index == CFG_BASE_PFN) begin
				base_q <= cfg_data;
			end else begin
				region_q <= cfg_data[REGION_W-1:0];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd == DC_DONE && stat.rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == DC_DONE && stat.rsp_free) begin
			rsp_q.result_frame <= res_q;
			rsp_q.status       <= st_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Working registers.
	always_ff @(posedge clk) begin
		case (cmd)
			DC_CFG: begin
				end_q <= EW'(base_q) + pages;
				pfn_q <= EW'(base_q);
				clr_q <= '0;
				for (int o = 0; o < NUM_ORDERS; o++) begin
					head_q[o] <= NIL;
				end
			end
			DC_CLEAR: begin
				clr_q <= clr_q + LW'(1);
			end
			DC_CARVE: begin
				cur_q  <= fit;
				pidx_q <= pfn_idx;
				pfn_q  <= pfn_q + (EW'(1) << fit);
			end
			DC_ACCEPT: begin
				cmd_q <= req.command;
				ord_q <= req.order;
				pfn_q <= EW'(req.page_frame);
			end
			DC_CHECK: begin
				cur_q <= ord_q;
				res_q <= '0;
				if (stat.bad_order) begin
					st_q <= ST_BAD_ORDER;
				end else if (stat.cmd_free && stat.out_range) begin
					st_q <= ST_OUTSIDE;
				end else begin
					st_q <= ST_OK;
				end
			end
			DC_SCAN: begin
				if (stat.head_valid) begin
					uidx_q <= head_cur[IW-1:0];
				end else if (stat.cur_last) begin
					st_q <= ST_NO_MEMORY;
				end else begin
					cur_q <= cur_q + ORD_W'(1);
				end
			end
			DC_UW1: begin
				if (prev_rd[IW] && head_cur == {1'b0, uidx_q}) begin
					head_q[cur_q[OW-1:0]] <= next_rd;
				end
			end
			DC_SPLIT: begin
				if (!stat.split_done) begin
					cur_q  <= cur_q - ORD_W'(1);
					pidx_q <= uidx_q + (IW'(1) << (cur_q - ORD_W'(1)));
				end
			end
			DC_PUSHA: begin
				h_q                   <= head_cur;
				head_q[cur_q[OW-1:0]] <= {1'b0, pidx_q};
			end
			DC_AFIN: begin
				res_q <= base_q + FRAME_W'(uidx_q);
			end
			DC_MEVAL: begin
				uidx_q <= bi;
			end
			DC_MPOST: begin
				if (bud < pfn_q) begin
					pfn_q <= bud;
				end
				cur_q <= cur_q + ORD_W'(1);
			end
			DC_FPUSH: begin
				pidx_q <= pfn_idx;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/buddy_page_allocator_core.sv @@
// Buddy page allocator: a word on req asks either to allocate a block of 2^order pages
// (command 0) or to free the block that starts at page_frame (command 1), and each word
// taken, unless a configuration write cuts it short, gives exactly one word on rsp with
// the allocated frame (zero for a free or an error) and a status: ok, out of memory, bad
// order or frame outside the region. After reset and after every write of base_pfn or
// region_pages the block runs an initialisation pass, during which req is stalled: a
// clearing pass over the free-mark memory, then a carving pass through the carve, push A
// and push B states per initial block. One request is handled at a time by a controller
// stepping a datapath built on four single-port-write metadata memories (next link,
// previous link, free mark, order), each with a registered read. An allocate scans the
// orders upward for a free block, unlinks it and splits it down; a free merges the block
// with its free buddies before linking it in. The result register lets the next request
// be taken while a finished result still waits on a stalled rsp.
module buddy_page_allocator_core import bpa_pkg::*; #(
	parameter int MAX_PAGES  = 65536,
	parameter int NUM_ORDERS = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [FRAME_W-1:0] cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_word_t          req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_word_t          rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     idle;

	// A configuration write takes priority over a request word in the same cycle.
	assign req_stall = !idle || cfg_we;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.req_valid (req_valid),
		.stat      (stat),
		.cmd       (cmd),
		.idle      (idle)
	);

	bpa_dp #(
		.MAX_PAGES  (MAX_PAGES),
		.NUM_ORDERS (NUM_ORDERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ hdl/bpa_checker.sv @@
`include "assert_macros.svh"

module bpa_checker import bpa_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cfg_we,
	input logic      req_valid,
	input logic      req_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_word_t rsp
);

	`ASSERT_IMPL(a_rsp_held, rsp_valid && rsp_stall, rsp_valid, "result word dropped while stalled")
	`ASSERT_CLK(a_err_zero, (rsp_valid && rsp.status != ST_OK) |-> (rsp.result_frame == '0), "error result carries a frame")
	`ASSERT_IMPL(a_one_at_time, req_valid && !req_stall, req_stall, "second request taken while busy")
	`ASSERT_IMPL(a_cfg_init, cfg_we, req_stall, "request taken during initialisation")

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (.*);
